// ----- rtl/core/plrh_pkg.sv -----
// ----------------------------------------------------------------------------
// plrh_pkg
// Shared types and constants of the pulse-length / reflectance histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package plrh_pkg;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_RD_LEN = 2'd1;
    localparam logic [1:0] CMD_RD_REF = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W      = 4;
    localparam logic [3:0]  REG_REFL_LIMIT = 4'd0;
    localparam logic [3:0]  REG_PLEN_LIMIT = 4'd1;

    // Field widths.
    localparam int REFL_LIMIT_W = 7;
    localparam int PLEN_LIMIT_W = 4;
    localparam int CFG_DATA_W   = 7;
    localparam int TOTAL_W      = 32;
    localparam int CROSS_SUM_W  = 39;

    localparam logic [REFL_LIMIT_W-1:0] REFL_LIMIT_RST = 7'd100;
    localparam logic [PLEN_LIMIT_W-1:0] PLEN_LIMIT_RST = 4'd15;

    // Tallies kept per bin: pulse counts one to four.
    localparam int NUM_TALLY   = 4;
    localparam int TALLY_SEL_W = 2;

    typedef struct packed {
        logic                   en;
        logic                   tally_en;
        logic [TALLY_SEL_W-1:0] tally_sel;
    } t_upd;

endpackage

`default_nettype wire

// ----- rtl/core/plrh_bin_table.sv -----
// ----------------------------------------------------------------------------
// plrh_bin_table
// One histogram table: a row per bin holding the point count, a cross sum
// and four pulse-count tallies, updated by read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module plrh_bin_table
    import plrh_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 32,
    parameter int SW    = 39,
    parameter int VW    = 7,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    input  wire t_upd                         i_upd,
    input  wire logic [VW-1:0]                i_upd_val,
    output logic      [CW-1:0]                o_points,
    output logic      [SW-1:0]                o_sum,
    output logic      [NUM_TALLY-1:0][CW-1:0] o_tally
);

    localparam int RW = NUM_TALLY * CW + SW + CW;

    logic [RW-1:0]                r_mem [DEPTH];
    logic [DEPTH-1:0]             r_vld;
    logic [AW-1:0]                r_addr;
    logic [AW-1:0]                r_fwd_addr;
    logic                         r_rd_vld;
    logic                         r_fwd_vld;
    logic [RW-1:0]                r_rd_row;
    logic [RW-1:0]                r_fwd_row;
    logic [RW-1:0]                w_cur_row;
    logic [RW-1:0]                n_row;
    logic [CW-1:0]                w_points;
    logic [CW-1:0]                n_points;
    logic [SW-1:0]                w_sum;
    logic [SW-1:0]                n_sum;
    logic [SW:0]                  w_sum_ext;
    logic [NUM_TALLY-1:0][CW-1:0] w_tally;
    logic [NUM_TALLY-1:0][CW-1:0] n_tally;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
        if (i_upd.en) begin
            r_mem[r_addr] <= n_row;
        end
    end

    // Rows are valid once written; an unwritten row reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_upd.en) begin
                r_vld[r_addr] <= 1'b1;
                r_fwd_vld     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr <= i_rd_addr;
        end
        if (i_upd.en) begin
            r_fwd_addr <= r_addr;
            r_fwd_row  <= n_row;
        end
    end

    // The last written row is held so that a read issued on the same edge
    // as the write to that row still sees the new contents.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_addr)) begin
            w_cur_row = r_fwd_row;
        end else if (r_rd_vld) begin
            w_cur_row = r_rd_row;
        end else begin
            w_cur_row = '0;
        end
    end

    assign {w_tally, w_sum, w_points} = w_cur_row;

    always_comb begin
        n_points  = (&w_points) ? w_points : w_points + CW'(1);
        w_sum_ext = {1'b0, w_sum} + (SW + 1)'(i_upd_val);
        n_sum     = w_sum_ext[SW] ? '1 : w_sum_ext[SW-1:0];
        n_tally   = w_tally;
        if (i_upd.tally_en && !(&w_tally[i_upd.tally_sel])) begin
            n_tally[i_upd.tally_sel] = w_tally[i_upd.tally_sel] + CW'(1);
        end
        n_row = {n_tally, n_sum, n_points};
    end

    assign o_points = w_points;
    assign o_sum    = w_sum;
    assign o_tally  = w_tally;

endmodule

`default_nettype wire

// ----- rtl/core/pulse_length_reflectance_histogram.sv -----
// An accepted item is held in the update stage, and its result is then registered in the output register.
// Throughput: one item per cycle while the output is taken; each table does one read and one
// write-back per cycle, and a repeat hit on a row is served by forwarding.
// Output backpressure holds the item in the update stage.
// Reset: synchronous; all tables read as zero at once through per-row valid
// bits, so items can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
// pulse_length_reflectance_histogram
// Histograms of laser return points over pulse-length bins and over reflectance
// bins, with saturating counts, cross sums and pulse-count tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_length_reflectance_histogram
    import plrh_pkg::*;
#(
    parameter int REFLECT_BINS = 128,
    parameter int LENGTH_BINS  = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [1:0]             i_command,
    input  wire logic [7:0]             i_reflectance,
    input  wire logic [7:0]             i_pulse_length,
    input  wire logic [2:0]             i_pulse_count,
    input  wire logic [6:0]             i_bin_index,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_accepted,
    output logic [TOTAL_W-1:0]          o_total_points,
    output logic [TOTAL_W-1:0]          o_bin_points,
    output logic [CROSS_SUM_W-1:0]      o_bin_cross_sum,
    output logic [TOTAL_W-1:0]          o_tally_pc_one,
    output logic [TOTAL_W-1:0]          o_tally_pc_two,
    output logic [TOTAL_W-1:0]          o_tally_pc_three,
    output logic [TOTAL_W-1:0]          o_tally_pc_four
);

    localparam int CW   = COUNT_WIDTH;
    localparam int LSW  = CW + REFL_LIMIT_W;
    localparam int RSW  = CW + PLEN_LIMIT_W;
    localparam int LA   = $clog2(LENGTH_BINS);
    localparam int RA   = $clog2(REFLECT_BINS);

    // Configuration.
    logic [REFL_LIMIT_W-1:0] r_refl_limit;
    logic [PLEN_LIMIT_W-1:0] r_plen_limit;

    // Issue stage.
    logic          w_in_acc;
    logic          w_adv;
    logic [7:0]    w_bin_ext;
    logic          w_len_fit;
    logic          w_ref_fit;
    logic          w_len_bin_fit;
    logic          w_ref_bin_fit;
    logic          w_add_ok;
    logic          w_len_rd;
    logic          w_ref_rd;
    logic [LA-1:0] w_len_addr;
    logic [RA-1:0] w_ref_addr;

    // Update stage.
    logic                    r_s1_vld;
    logic [1:0]              r_s1_cmd;
    logic                    r_s1_acc;
    logic                    r_s1_len_hit;
    logic                    r_s1_ref_hit;
    logic                    r_s1_tally_en;
    logic [TALLY_SEL_W-1:0]  r_s1_tally_sel;
    logic [REFL_LIMIT_W-1:0] r_s1_refl;
    logic [PLEN_LIMIT_W-1:0] r_s1_plen;
    logic [CW-1:0]           r_total;
    logic [CW-1:0]           n_total;
    t_upd                    w_upd;

    // Table rows.
    logic [CW-1:0]                w_len_points;
    logic [LSW-1:0]               w_len_sum;
    logic [NUM_TALLY-1:0][CW-1:0] w_len_tally;
    logic [CW-1:0]                w_ref_points;
    logic [RSW-1:0]               w_ref_sum;
    logic [NUM_TALLY-1:0][CW-1:0] w_ref_tally;

    // Result selection.
    logic                         w_sel_hit;
    logic [CW-1:0]                w_sel_points;
    logic [LSW-1:0]               w_sel_sum;
    logic [NUM_TALLY-1:0][CW-1:0] w_sel_tally;
    logic [63:0]                  w_total64;
    logic [63:0]                  w_pts64;
    logic [63:0]                  w_sum64;
    logic [NUM_TALLY-1:0][63:0]   w_tal64;

    // Output register.
    logic                   r_out_vld;
    logic                   r_out_acc;
    logic [TOTAL_W-1:0]     r_out_total;
    logic [TOTAL_W-1:0]     r_out_points;
    logic [CROSS_SUM_W-1:0] r_out_sum;
    logic [TOTAL_W-1:0]     r_out_tally [NUM_TALLY];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refl_limit <= REFL_LIMIT_RST;
            r_plen_limit <= PLEN_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REFL_LIMIT: r_refl_limit <= i_cfg_wdata;
                REG_PLEN_LIMIT: r_plen_limit <= i_cfg_wdata[PLEN_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Issue: range checks and table reads
    // ------------------------------------------------------------------
    assign w_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_bin_ext     = {1'b0, i_bin_index};
    assign w_len_fit     = {1'b0, i_pulse_length} < 9'(LENGTH_BINS);
    assign w_ref_fit     = {1'b0, i_reflectance} < 9'(REFLECT_BINS);
    assign w_len_bin_fit = {1'b0, w_bin_ext} < 9'(LENGTH_BINS);
    assign w_ref_bin_fit = {1'b0, w_bin_ext} < 9'(REFLECT_BINS);
    assign w_add_ok      = (i_command == CMD_ADD)
                        && (i_reflectance <= {1'b0, r_refl_limit})
                        && (i_pulse_length <= {4'b0, r_plen_limit})
                        && w_len_fit && w_ref_fit;

    always_comb begin
        w_len_rd   = 1'b0;
        w_ref_rd   = 1'b0;
        w_len_addr = w_bin_ext[LA-1:0];
        w_ref_addr = w_bin_ext[RA-1:0];
        unique case (i_command)
            CMD_ADD: begin
                w_len_rd   = w_add_ok;
                w_ref_rd   = w_add_ok;
                w_len_addr = i_pulse_length[LA-1:0];
                w_ref_addr = i_reflectance[RA-1:0];
            end
            CMD_RD_LEN: w_len_rd = w_len_bin_fit;
            CMD_RD_REF: w_ref_rd = w_ref_bin_fit;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd       <= i_command;
            r_s1_acc       <= w_add_ok;
            r_s1_len_hit   <= w_len_rd;
            r_s1_ref_hit   <= w_ref_rd;
            r_s1_tally_en  <= (i_pulse_count != 3'd0) && (i_pulse_count <= 3'(NUM_TALLY));
            r_s1_tally_sel <= TALLY_SEL_W'(i_pulse_count - 3'd1);
            r_s1_refl      <= i_reflectance[REFL_LIMIT_W-1:0];
            r_s1_plen      <= i_pulse_length[PLEN_LIMIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Update: tables and running total
    // ------------------------------------------------------------------
    assign w_upd.en        = w_adv && r_s1_acc;
    assign w_upd.tally_en  = r_s1_tally_en;
    assign w_upd.tally_sel = r_s1_tally_sel;

    plrh_bin_table #(
        .DEPTH (LENGTH_BINS),
        .CW    (CW),
        .SW    (LSW),
        .VW    (REFL_LIMIT_W)
    ) u_len_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc && w_len_rd),
        .i_rd_addr (w_len_addr),
        .i_upd     (w_upd),
        .i_upd_val (r_s1_refl),
        .o_points  (w_len_points),
        .o_sum     (w_len_sum),
        .o_tally   (w_len_tally)
    );

    plrh_bin_table #(
        .DEPTH (REFLECT_BINS),
        .CW    (CW),
        .SW    (RSW),
        .VW    (PLEN_LIMIT_W)
    ) u_ref_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc && w_ref_rd),
        .i_rd_addr (w_ref_addr),
        .i_upd     (w_upd),
        .i_upd_val (r_s1_plen),
        .o_points  (w_ref_points),
        .o_sum     (w_ref_sum),
        .o_tally   (w_ref_tally)
    );

    assign n_total = (r_s1_acc && !(&r_total)) ? r_total + CW'(1) : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_adv) begin
            r_total <= n_total;
        end
    end

    // ------------------------------------------------------------------
    // Result selection and output register
    // ------------------------------------------------------------------
    always_comb begin
        w_sel_hit    = 1'b0;
        w_sel_points = w_len_points;
        w_sel_sum    = w_len_sum;
        w_sel_tally  = w_len_tally;
        unique case (r_s1_cmd)
            CMD_RD_LEN: w_sel_hit = r_s1_len_hit;
            CMD_RD_REF: begin
                w_sel_hit    = r_s1_ref_hit;
                w_sel_points = w_ref_points;
                w_sel_sum    = LSW'(w_ref_sum);
                w_sel_tally  = w_ref_tally;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_total64 = 64'(n_total);
        w_pts64   = w_sel_hit ? 64'(w_sel_points) : '0;
        w_sum64   = w_sel_hit ? 64'(w_sel_sum) : '0;
        for (int k = 0; k < NUM_TALLY; k++) begin
            w_tal64[k] = w_sel_hit ? 64'(w_sel_tally[k]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_acc    <= r_s1_acc;
            r_out_total  <= w_total64[TOTAL_W-1:0];
            r_out_points <= w_pts64[TOTAL_W-1:0];
            r_out_sum    <= w_sum64[CROSS_SUM_W-1:0];
            for (int k = 0; k < NUM_TALLY; k++) begin
                r_out_tally[k] <= w_tal64[k][TOTAL_W-1:0];
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_accepted       = r_out_acc;
    assign o_total_points   = r_out_total;
    assign o_bin_points     = r_out_points;
    assign o_bin_cross_sum  = r_out_sum;
    assign o_tally_pc_one   = r_out_tally[0];
    assign o_tally_pc_two   = r_out_tally[1];
    assign o_tally_pc_three = r_out_tally[2];
    assign o_tally_pc_four  = r_out_tally[3];

endmodule

`default_nettype wire

// ----- rtl/core/plrh_checker.sv -----
// ----------------------------------------------------------------------------
// plrh_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plrh_checker
    import plrh_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic                   o_accepted,
    input wire logic [TOTAL_W-1:0]     o_total_points,
    input wire logic [TOTAL_W-1:0]     o_bin_points,
    input wire logic [CROSS_SUM_W-1:0] o_bin_cross_sum,
    input wire logic [TOTAL_W-1:0]     o_tally_pc_one,
    input wire logic [TOTAL_W-1:0]     o_tally_pc_two,
    input wire logic [TOTAL_W-1:0]     o_tally_pc_three,
    input wire logic [TOTAL_W-1:0]     o_tally_pc_four
);

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result that is not taken keeps its valid, flag, total, bin points and cross sum.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_points)
            && $stable(o_accepted) && $stable(o_bin_points)
            && $stable(o_bin_cross_sum))
        else $error("result changed while stalled");

    // A counted point has been added to the total.
    a_acc_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_total_points != '0)
        else $error("counted point with zero total");

    // A counted add returns no bin contents.
    a_acc_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_bin_points == '0 && o_bin_cross_sum == '0
            && o_tally_pc_one == '0 && o_tally_pc_two == '0
            && o_tally_pc_three == '0 && o_tally_pc_four == '0)
        else $error("bin fields set on an add result");

endmodule

bind pulse_length_reflectance_histogram plrh_checker u_plrh_checker (.*);

`default_nettype wire
